// ===== design/surfel_depth_map_association_unit_macros.svh =====
// assertion helpers for the depth association block
`ifndef SURFEL_DEPTH_MAP_ASSOCIATION_UNIT_MACROS_SVH
`define SURFEL_DEPTH_MAP_ASSOCIATION_UNIT_MACROS_SVH

// implication checked on every edge out of reset
`define SDA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked out of reset
`define SDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/sdma_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sdma_pkg;

  localparam int ImageWidth  = 640;
  localparam int ImageHeight = 480;
  localparam int PixCount    = ImageWidth * ImageHeight;
  localparam int AddrW       = $clog2(PixCount);

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ASSOC  = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] CLS_MATCH   = 3'd0;
  localparam logic [2:0] CLS_BEHIND  = 3'd1;
  localparam logic [2:0] CLS_FRONT   = 3'd2;
  localparam logic [2:0] CLS_INVALID = 3'd3;
  localparam logic [2:0] CLS_OUTSIDE = 3'd4;
  localparam logic [2:0] CLS_NONE    = 3'd5;

  localparam logic [2:0] REG_FOCAL_X  = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y  = 3'd1;
  localparam logic [2:0] REG_CENTER_X = 3'd2;
  localparam logic [2:0] REG_CENTER_Y = 3'd3;
  localparam logic [2:0] REG_TOL      = 3'd4;
  localparam logic [2:0] REG_NEAR     = 3'd5;
  localparam logic [2:0] REG_FAR      = 3'd6;

  // product 26x32 signed -> 59 bits
  localparam int NumW = 59;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_DIV_X,
    ST_DIV_Y,
    ST_PROJ,
    ST_RD,
    ST_RDWAIT,
    ST_CLASS,
    ST_OUT
  } sdma_state_t;

  // divider handshake
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// ===== design/sdma_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// signed floor division of a 59-bit numerator by a positive 31-bit divisor,
// one quotient bit per cycle on magnitudes
module sdma_divider
  import sdma_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire div_ctl_t               ctl,
  input  wire logic signed [NumW-1:0] num,
  input  wire logic        [30:0]     den,
  output      div_sts_t               sts,
  output      logic signed [NumW-1:0] quo
);

  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] q_r, q_nxt;
  logic [31:0]     rem_r, rem_nxt;
  logic [30:0]     den_r;
  logic            neg_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [NumW-1:0] mag;
  logic [32:0]     trial;
  logic [NumW-1:0] qmag;

  assign mag = num[NumW-1] ? (~num + 1'b1) : num;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = '0;
    if (ctl.start) begin
      q_nxt    = mag;
      rem_nxt  = '0;
      cnt_nxt  = CntW'(NumW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      trial = {rem_r, q_r[NumW-1]} - {2'b00, den_r};
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        q_nxt   = {q_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], q_r[NumW-1]};
        q_nxt   = {q_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) begin
      den_r <= den;
      neg_r <= num[NumW-1];
    end
  end

  // floor for negative numerators: -(mag/den) - (rem != 0)
  assign qmag = q_r;
  assign quo  = neg_r ? ($signed(~qmag + 1'b1) - $signed({{(NumW-1){1'b0}}, (rem_r != '0)}))
                      : $signed(qmag);
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule
`default_nettype wire

// ===== design/surfel_depth_map_association_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Depth association unit: a 640x480 depth map with covered marks, kept in
// synchronous on-chip memory, and a projective point classifier.
// Input channel (in_valid/in_ready) carries one operation per transfer:
// load a depth pixel, associate a surfel point, or query a pixel.
// Result channel (out_valid/out_ready) returns exactly one result per
// transfer, held in an output register until taken.
// A load inside the image passes ST_MUL_X, ST_RD and ST_OUT; a query
// adds ST_RDWAIT and ST_CLASS before ST_OUT; a load or query off the
// image, an unused opcode or a point with z <= 0 goes from ST_MUL_X to
// ST_OUT. For a point, both image coordinates go through one shared
// radix-2 divider, one quotient bit per cycle over 59 bits, for the
// division by depth. One item is in work at a time; in_ready rises the
// cycle after a result is loaded. The user must write intrinsics and limits
// through the configuration port only at idle; the block does not enforce it.
// Reset (synchronous, rst_n low) restores register defaults and empties the
// result register; map contents stay undefined until pixels are loaded.
// A stalled receiver holds the result; the next item still runs and waits
// at its end until the result register is free.
module surfel_depth_map_association_unit
  import sdma_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [25:0]        cfg_data,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [1:0]         in_opcode,
  input  wire logic [8:0]         in_pixel_row,
  input  wire logic [9:0]         in_pixel_col,
  input  wire logic [19:0]        in_depth_value,
  input  wire logic               in_depth_present,
  input  wire logic signed [31:0] in_point_x,
  input  wire logic signed [31:0] in_point_y,
  input  wire logic signed [31:0] in_point_z,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [2:0]         out_match_class,
  output      logic [8:0]         out_hit_row,
  output      logic [9:0]         out_hit_col,
  output      logic               out_add_pixel
);

  logic [25:0] focal_x_r, focal_y_r, center_x_r, center_y_r;
  logic [19:0] tol_r, near_r, far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focal_x_r  <= 26'd34008474;
      focal_y_r  <= 26'd33895822;
      center_x_r <= 26'd21199832;
      center_y_r <= 26'd17064391;
      tol_r      <= 20'd3277;
      near_r     <= 20'd52429;
      far_r      <= 20'd262144;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FOCAL_X:  focal_x_r  <= cfg_data;
        REG_FOCAL_Y:  focal_y_r  <= cfg_data;
        REG_CENTER_X: center_x_r <= cfg_data;
        REG_CENTER_Y: center_y_r <= cfg_data;
        REG_TOL:      tol_r      <= cfg_data[19:0];
        REG_NEAR:     near_r     <= cfg_data[19:0];
        REG_FAR:      far_r      <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // depth map and covered marks
  logic [20:0] depth_mem [PixCount];
  logic        cov_mem [PixCount];
  logic [AddrW-1:0] mem_addr;
  logic        dm_we, cov_we, cov_wd;
  logic [20:0] dm_wd;
  logic [20:0] dm_rd_r;
  logic        cov_rd_r;

  always_ff @(posedge clk) begin
    if (dm_we) depth_mem[mem_addr] <= dm_wd;
    dm_rd_r <= depth_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cov_we) cov_mem[mem_addr] <= cov_wd;
    cov_rd_r <= cov_mem[mem_addr];
  end

  sdma_state_t state_r, state_nxt;

  logic [1:0]         op_r;
  logic [8:0]         row_r;
  logic [9:0]         col_r;
  logic [19:0]        dval_r;
  logic               pres_r;
  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [NumW-1:0] prod_r;
  logic signed [NumW-1:0] qx_r;
  logic               yphase_r, yphase_nxt;

  logic               ov_r, ov_nxt;
  logic [2:0]         ocls_r, ocls_nxt;
  logic [8:0]         orow_r, orow_nxt;
  logic [9:0]         ocol_r, ocol_nxt;
  logic               oadd_r, oadd_nxt;

  // result register seen on the output ports
  logic [2:0]         rcls_r;
  logic [8:0]         rrow_r;
  logic [9:0]         rcol_r;
  logic               radd_r;
  logic               res_load;

  div_ctl_t dctl;
  div_sts_t dsts;
  logic signed [NumW-1:0] dquo;
  logic signed [NumW-1:0] prod_nxt;
  logic                   prod_load;

  sdma_divider u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (dctl),
    .num  (prod_r),
    .den  (pz_r[30:0]),
    .sts  (dsts),
    .quo  (dquo)
  );

  // projection tails
  logic signed [NumW+1:0] tx, ty;
  logic                   okx, oky;
  logic [9:0]             pcol;
  logic [8:0]             prow;
  logic [AddrW-1:0]       pt_addr, px_addr;
  logic                   in_img;
  logic signed [32:0]     diff;
  logic signed [32:0]     tol_s;

  always_comb begin
    tx = $signed({{2{qx_r[NumW-1]}}, qx_r}) + $signed({(NumW+2-26)'(0), center_x_r})
         + (NumW+2)'(32768);
    ty = $signed({{2{dquo[NumW-1]}}, dquo}) + $signed({(NumW+2-26)'(0), center_y_r})
         + (NumW+2)'(32768);
    okx = (tx > 0) && (tx[NumW+1:16] < (NumW-14)'(ImageWidth));
    oky = (ty > 0) && (ty[NumW+1:16] < (NumW-14)'(ImageHeight));
    pcol = tx[25:16];
    prow = ty[24:16];
    pt_addr = AddrW'(prow) * AddrW'(ImageWidth) + AddrW'(pcol);
    px_addr = AddrW'(row_r) * AddrW'(ImageWidth) + AddrW'(col_r);
    in_img  = (row_r < 9'(ImageHeight)) && (col_r < 10'(ImageWidth));
    diff  = $signed({13'b0, dm_rd_r[19:0]}) - $signed({pz_r[31], pz_r});
    tol_s = $signed({13'b0, tol_r});
  end

  logic [AddrW-1:0] addr_r, addr_nxt;
  logic out_take;

  assign out_take = ov_r && out_ready;
  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    yphase_nxt = yphase_r;
    ov_nxt     = ov_r && !out_ready;
    ocls_nxt   = ocls_r;
    orow_nxt   = orow_r;
    ocol_nxt   = ocol_r;
    oadd_nxt   = oadd_r;
    addr_nxt   = addr_r;
    dctl.start = 1'b0;
    dm_we      = 1'b0;
    cov_we     = 1'b0;
    cov_wd     = 1'b0;
    dm_wd      = '0;
    mem_addr   = addr_r;
    prod_load  = 1'b0;
    prod_nxt   = prod_r;
    res_load   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        if (op_r == OP_ASSOC) begin
          prod_load = 1'b1;
          prod_nxt  = $signed({1'b0, focal_x_r}) * px_r;
          if (pz_r <= 0) begin
            ocls_nxt = CLS_OUTSIDE; orow_nxt = '0; ocol_nxt = '0; oadd_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            yphase_nxt = 1'b0;
            state_nxt  = ST_DIV_X;
          end
        end else if (op_r == OP_UNUSED) begin
          ocls_nxt = CLS_NONE; orow_nxt = '0; ocol_nxt = '0; oadd_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          ocls_nxt = CLS_NONE; orow_nxt = row_r; ocol_nxt = col_r; oadd_nxt = 1'b0;
          addr_nxt = px_addr;
          state_nxt = in_img ? ST_RD : ST_OUT;
        end
      end
      ST_DIV_X: begin
        dctl.start = 1'b1;
        state_nxt  = ST_DIV_Y;
      end
      ST_DIV_Y: begin
        if (dsts.done) begin
          if (!yphase_r) begin
            prod_load  = 1'b1;
            prod_nxt   = $signed({1'b0, focal_y_r}) * py_r;
            yphase_nxt = 1'b1;
            state_nxt  = ST_DIV_X;
          end else begin
            state_nxt = ST_PROJ;
          end
        end
      end
      ST_PROJ: begin
        if (!(okx && oky)) begin
          ocls_nxt = CLS_OUTSIDE; orow_nxt = '0; ocol_nxt = '0; oadd_nxt = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          orow_nxt = prow; ocol_nxt = pcol; oadd_nxt = 1'b0;
          addr_nxt = pt_addr;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // load writes straight away, others read
        if (op_r == OP_LOAD) begin
          dm_we  = 1'b1;
          cov_we = 1'b1;
          dm_wd  = {pres_r && (dval_r >= near_r) && (dval_r <= far_r), dval_r};
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_RDWAIT;
        end
      end
      ST_RDWAIT: state_nxt = ST_CLASS;
      ST_CLASS: begin
        if (op_r == OP_QUERY) begin
          oadd_nxt = dm_rd_r[20] && !cov_rd_r;
        end else if (!dm_rd_r[20]) begin
          ocls_nxt = CLS_INVALID;
        end else if (diff <= tol_s && diff >= -tol_s) begin
          ocls_nxt = CLS_MATCH; cov_we = 1'b1; cov_wd = 1'b1;
        end else if (diff > tol_s) begin
          ocls_nxt = CLS_BEHIND; cov_we = 1'b1; cov_wd = 1'b1;
        end else begin
          ocls_nxt = CLS_FRONT;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      ov_r     <= 1'b0;
      yphase_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ov_r     <= ov_nxt;
      yphase_r <= yphase_nxt;
    end
    ocls_r <= ocls_nxt;
    orow_r <= orow_nxt;
    ocol_r <= ocol_nxt;
    oadd_r <= oadd_nxt;
    addr_r <= addr_nxt;
    if (res_load) begin
      rcls_r <= ocls_r;
      rrow_r <= orow_r;
      rcol_r <= ocol_r;
      radd_r <= oadd_r;
    end
    if (prod_load) prod_r <= prod_nxt;
    if (state_r == ST_DIV_Y && dsts.done && !yphase_r) qx_r <= dquo;
    if (in_valid && in_ready) begin
      op_r   <= in_opcode;
      row_r  <= in_pixel_row;
      col_r  <= in_pixel_col;
      dval_r <= in_depth_value;
      pres_r <= in_depth_present;
      px_r   <= in_point_x;
      py_r   <= in_point_y;
      pz_r   <= in_point_z;
    end
  end

  assign out_valid       = ov_r;
  assign out_match_class = rcls_r;
  assign out_hit_row     = rrow_r;
  assign out_hit_col     = rcol_r;
  assign out_add_pixel   = radd_r;

endmodule
`default_nettype wire

// ===== design/sdma_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "surfel_depth_map_association_unit_macros.svh"
module sdma_checker
  import sdma_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_match_class,
  input wire logic       out_add_pixel
);

  `SDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped")
  `SDA_ASSERT_IMPL(a_cls_range, clk, rst_n, out_valid, out_match_class <= CLS_NONE, "bad class")
  `SDA_ASSERT_IMPL(a_add_only_query, clk, rst_n, out_valid && out_add_pixel,
    out_match_class == CLS_NONE, "add flag on a point result")
  `SDA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready,
    "second transfer while busy")

endmodule

bind surfel_depth_map_association_unit sdma_checker u_sdma_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_match_class(out_match_class),
  .out_add_pixel  (out_add_pixel)
);
`default_nettype wire

// ===== tb/surfel_depth_map_association_unit_test.sv =====
`timescale 1ns / 1ps
module surfel_depth_map_association_unit_test;
  import sdma_pkg::*;

  typedef struct {
    logic [1:0]         op;
    logic [8:0]         row;
    logic [9:0]         col;
    logic [19:0]        dval;
    logic               dpres;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
  } op_item_t;

  typedef struct {
    logic [2:0] cls;
    logic [8:0] row;
    logic [9:0] col;
    logic       add;
  } assoc_res_t;

  typedef struct {
    op_item_t   it;
    bit         has_res;
    assoc_res_t res;
  } dir_row_t;

  localparam int WatchLimit = 20000;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [25:0]        cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_opcode;
  logic [8:0]         in_pixel_row;
  logic [9:0]         in_pixel_col;
  logic [19:0]        in_depth_value;
  logic               in_depth_present;
  logic signed [31:0] in_point_x;
  logic signed [31:0] in_point_y;
  logic signed [31:0] in_point_z;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_match_class;
  logic [8:0]         out_hit_row;
  logic [9:0]         out_hit_col;
  logic               out_add_pixel;

  surfel_depth_map_association_unit uut (.*);

  // predictor copy of registers and maps
  longint     fx, fy, cx, cy, tol, near_d, far_d;
  logic [20:0] depth_store[int];
  bit          cover_store[int];
  int          loaded_px[$];
  assoc_res_t  expected_res[$];
  int          errors;
  int          in_idle_pct;
  int          out_idle_pct;
  int          quiet_cycles;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit project_axis(input longint focal, input longint center,
                                      input longint c, input longint z,
                                      input longint limit, output longint idx);
    longint num, q, t;
    num = focal * c;
    q = num / z;
    if ((num % z) != 0 && num < 0) q = q - 1;
    t = q + center + 32768;
    idx = 0;
    if (t <= 0) return 0;
    idx = t >>> 16;
    return idx < limit;
  endfunction

  function automatic bit locate_pixel(input op_item_t it, output int k,
                                      output longint pr, output longint pc);
    longint z;
    z = it.pz;
    k = 0;
    pr = 0;
    pc = 0;
    if (z <= 0) return 0;
    if (!project_axis(fx, cx, it.px, z, ImageWidth, pc)) return 0;
    if (!project_axis(fy, cy, it.py, z, ImageHeight, pr)) return 0;
    k = int'(pr) * ImageWidth + int'(pc);
    return 1;
  endfunction

  function automatic assoc_res_t predict_assoc(input op_item_t it);
    assoc_res_t r;
    int k;
    longint pr, pc, diff;
    bit ok;
    r = '{CLS_NONE, 0, 0, 0};
    if (it.op == OP_LOAD || it.op == OP_QUERY) begin
      r.row = it.row;
      r.col = it.col;
      if (it.row < ImageHeight && it.col < ImageWidth) begin
        k = int'(it.row) * ImageWidth + int'(it.col);
        if (it.op == OP_LOAD) begin
          ok = it.dpres && it.dval >= near_d && it.dval <= far_d;
          if (!depth_store.exists(k)) loaded_px.insert(loaded_px.size(), k);
          depth_store[k] = {ok, it.dval};
          cover_store[k] = 0;
        end else begin
          r.add = depth_store.exists(k) && depth_store[k][20] && !cover_store[k];
        end
      end
    end else if (it.op == OP_ASSOC) begin
      r.cls = CLS_OUTSIDE;
      if (locate_pixel(it, k, pr, pc)) begin
        r.row = pr[8:0];
        r.col = pc[9:0];
        if (!depth_store.exists(k) || !depth_store[k][20]) begin
          r.cls = CLS_INVALID;
        end else begin
          diff = longint'(depth_store[k][19:0]) - longint'(it.pz);
          if (diff <= tol && diff >= -tol) begin
            r.cls = CLS_MATCH;
            cover_store[k] = 1;
          end else if (diff > tol) begin
            r.cls = CLS_BEHIND;
            cover_store[k] = 1;
          end else begin
            r.cls = CLS_FRONT;
          end
        end
      end
    end
    return r;
  endfunction

  // drive one transfer; called right after a rising edge
  task automatic send_item(input op_item_t it, input bit has_res, input assoc_res_t res);
    int gap;
    assoc_res_t p;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= it.op;
    in_pixel_row <= it.row;
    in_pixel_col <= it.col;
    in_depth_value <= it.dval;
    in_depth_present <= it.dpres;
    in_point_x <= it.px;
    in_point_y <= it.py;
    in_point_z <= it.pz;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = predict_assoc(it);
    expected_res.insert(expected_res.size(), has_res ? res : p);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_res.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // write enable is left high; set_regs drops it after the last write
  task automatic write_reg(input logic [2:0] idx, input longint val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[25:0];
    @(posedge clk);
    case (idx)
      REG_FOCAL_X:  fx = val & 64'h3FFFFFF;
      REG_FOCAL_Y:  fy = val & 64'h3FFFFFF;
      REG_CENTER_X: cx = val & 64'h3FFFFFF;
      REG_CENTER_Y: cy = val & 64'h3FFFFFF;
      REG_TOL:      tol = val & 64'hFFFFF;
      REG_NEAR:     near_d = val & 64'hFFFFF;
      REG_FAR:      far_d = val & 64'hFFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint a, b, c, d, e, f, g);
    write_reg(REG_FOCAL_X, a);
    write_reg(REG_FOCAL_Y, b);
    write_reg(REG_CENTER_X, c);
    write_reg(REG_CENTER_Y, d);
    write_reg(REG_TOL, e);
    write_reg(REG_NEAR, f);
    write_reg(REG_FAR, g);
    cfg_we <= 1'b0;
  endtask

  function automatic op_item_t mk(input logic [1:0] op, input int row, input int col,
                                  input int dval, input bit dpres,
                                  input longint x, input longint y, input longint z);
    op_item_t it;
    it.op = op;
    it.row = row[8:0];
    it.col = col[9:0];
    it.dval = dval[19:0];
    it.dpres = dpres;
    it.px = x[31:0];
    it.py = y[31:0];
    it.pz = z[31:0];
    return it;
  endfunction

  function automatic op_item_t junk_item(input logic [1:0] op);
    return mk(op, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  // a point aimed at a random pixel unless noise is set, with a depth near the loaded scan
  task automatic send_aimed_point(input bit noise, output int sent);
    op_item_t it, ld;
    assoc_res_t none;
    longint z, tu, tv, pr, pc, dlt, span, d;
    int k, col, row, pick;
    none = '{CLS_NONE, 0, 0, 0};
    sent = 0;
    pick = $urandom_range(99);
    if (pick < 80) z = $urandom_range(20000, 1000000);
    else if (pick < 88) z = $urandom_range(1, 32'h7FFFFFFF);
    else if (pick < 94) z = $urandom_range(1, 100);
    else z = -longint'($urandom_range(0, 32'h7FFFFFFF)) - 1 + ($urandom_range(1) ? 1 : 0);
    col = $urandom_range(0, ImageWidth - 1);
    row = $urandom_range(0, ImageHeight - 1);
    tu = longint'(col) * 65536 + $urandom_range(0, 65535) - 32768;
    tv = longint'(row) * 65536 + $urandom_range(0, 65535) - 32768;
    it = junk_item(OP_ASSOC);
    it.pz = z[31:0];
    if (!noise) begin
      if (fx != 0) it.px = 32'(((tu - cx) * z) / fx);
      if (fy != 0) it.py = 32'(((tv - cy) * z) / fy);
    end
    if (locate_pixel(it, k, pr, pc) && (!depth_store.exists(k) || $urandom_range(99) < 40)) begin
      span = (tol > 100000) ? 100000 : tol;
      dlt = longint'($urandom_range(0, 4 * span + 20)) - (2 * span + 10);
      d = longint'(it.pz) + dlt;
      if (d < 0) d = 0;
      if (d > 1048575) d = 1048575;
      ld = mk(OP_LOAD, int'(pr), int'(pc), int'(d), $urandom_range(99) < 90, $urandom,
              $urandom, $urandom);
      send_item(ld, 0, none);
      sent++;
    end
    send_item(it, 0, none);
    sent++;
  endtask

  task automatic run_random(input int count, input int pct_in, input int pct_out,
                            input bit pause_midway);
    op_item_t it;
    assoc_res_t none;
    int done, pick, n;
    bit paused;
    none = '{CLS_NONE, 0, 0, 0};
    in_idle_pct = pct_in;
    out_idle_pct = pct_out;
    done = 0;
    paused = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      n = 1;
      if (pick < 45) begin
        send_aimed_point(0, n);
      end else if (pick < 55) begin
        send_aimed_point(1, n);
      end else if (pick < 72) begin
        it = junk_item(OP_LOAD);
        it.row = 9'($urandom_range(0, ImageHeight - 1));
        it.col = 10'($urandom_range(0, ImageWidth - 1));
        send_item(it, 0, none);
      end else if (pick < 88 && loaded_px.size() != 0) begin
        it = junk_item(OP_QUERY);
        n = loaded_px[$urandom_range(0, loaded_px.size() - 1)];
        it.row = 9'(n / ImageWidth);
        it.col = 10'(n % ImageWidth);
        n = 1;
        send_item(it, 0, none);
      end else if (pick < 95) begin
        // loads and queries that fall off the image
        it = junk_item($urandom_range(1) ? OP_LOAD : OP_QUERY);
        if ($urandom_range(1)) it.row = 9'($urandom_range(ImageHeight, 511));
        else it.col = 10'($urandom_range(ImageWidth, 1023));
        send_item(it, 0, none);
      end else begin
        send_item(junk_item(OP_UNUSED), 0, none);
      end
      done += n;
      if (pause_midway && !paused && done >= count / 2) begin
        paused = 1;
        drain;
      end
    end
    drain;
  endtask

  always @(posedge clk) begin
    assoc_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        errors++;
        $display("%0t unexpected result class %0d", $time, out_match_class);
      end else begin
        e = expected_res.pop_front();
        if (out_match_class !== e.cls || out_hit_row !== e.row || out_hit_col !== e.col ||
            out_add_pixel !== e.add) begin
          errors++;
          if (errors < 40)
            $display("%0t mismatch: expected cls %0d row %0d col %0d add %0d, got cls %0d row %0d col %0d add %0d",
                     $time, e.cls, e.row, e.col, e.add, out_match_class, out_hit_row,
                     out_hit_col, out_add_pixel);
        end
      end
    end
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchLimit) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    dir_row_t tbl[$];
    assoc_res_t none;
    none = '{CLS_NONE, 0, 0, 0};
    errors = 0;
    quiet_cycles = 0;
    in_idle_pct = 11;
    out_idle_pct = 52;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_opcode = OP_LOAD;
    in_pixel_row = '0;
    in_pixel_col = '0;
    in_depth_value = '0;
    in_depth_present = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_point_z = '0;
    fx = 34008474;
    fy = 33895822;
    cx = 21199832;
    cy = 17064391;
    tol = 3277;
    near_d = 52429;
    far_d = 262144;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset intrinsics put the origin ray on row 260, column 323
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 0, 0, 100000, 1, 0, 0, 0), 1, '{CLS_NONE, 0, 0, 0}});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 0, 0, 0, 0, 0, 0, 0), 1, '{CLS_NONE, 0, 0, 1}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 479, 639, 0, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 479, 639, 0}});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 479, 639, 0, 0, 0, 0, 0), 1,
                             '{CLS_NONE, 479, 639, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 479, 639, 1048575, 0, 0, 0, 0), 1,
                             '{CLS_NONE, 479, 639, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 511, 1023, 1048575, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 511, 1023, 0}});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 500, 700, 0, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 500, 700, 0}});
    tbl.insert(tbl.size(), '{mk(OP_UNUSED, 511, 1023, 1048575, 1, -1, -1, -1), 1, none});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 0), 1, '{CLS_OUTSIDE, 0, 0, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, -2147483648), 1,
                             '{CLS_OUTSIDE, 0, 0, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 2147483647, 0, 1), 1,
                             '{CLS_OUTSIDE, 0, 0, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, -2147483648, 1), 1,
                             '{CLS_OUTSIDE, 0, 0, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 260, 323, 131072, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 131072), 1,
                             '{CLS_MATCH, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 260, 323, 0, 0, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 260, 323, 196608, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 260, 323, 0, 0, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 1}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 131072), 1,
                             '{CLS_BEHIND, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 260, 323, 131072, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 196608), 1,
                             '{CLS_FRONT, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 127795), 1,
                             '{CLS_MATCH, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 260, 323, 40000, 1, 0, 0, 0), 1,
                             '{CLS_NONE, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_ASSOC, 0, 0, 0, 0, 0, 0, 40000), 1,
                             '{CLS_INVALID, 260, 323, 0}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 1, 1, 52429, 1, 0, 0, 0), 0, none});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 1, 1, 0, 0, 0, 0, 0), 1, '{CLS_NONE, 1, 1, 1}});
    tbl.insert(tbl.size(), '{mk(OP_LOAD, 2, 2, 262145, 1, 0, 0, 0), 0, none});
    tbl.insert(tbl.size(), '{mk(OP_QUERY, 2, 2, 0, 0, 0, 0, 0), 1, '{CLS_NONE, 2, 2, 0}});
    foreach (tbl[i]) send_item(tbl[i].it, tbl[i].has_res, tbl[i].res);
    drain;

    set_regs(34008474, 33895822, 21199832, 17064391, 3277, 52429, 262144);
    run_random(420, 11, 52, 1);
    // extremes: widest x focal, flat y focal, principal point on the left edge, zero tolerance
    set_regs(67108863, 0, 0, 15728640, 0, 0, 1048575);
    run_random(250, 52, 11, 0);
    // near above far: no loaded pixel is valid
    set_regs(20000000, 20000000, 67108863, 0, 1048575, 1048575, 0);
    run_random(150, 52, 11, 0);
    set_regs(30000000, 30000000, 20971520, 15728640, 20000, 10000, 900000);
    run_random(430, 0, 0, 0);

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
